@@ sv/petscii_stream_decoder_defines.svh @@
// assertion macros used by the petscii stream decoder top level
`ifndef PETSCII_STREAM_DECODER_DEFINES_SVH
`define PETSCII_STREAM_DECODER_DEFINES_SVH

// antecedent holds at an edge, consequent holds at the same edge
`define PSD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psd assertion failed");

// antecedent holds at an edge, consequent holds at the next edge
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psd assertion failed");

`endif

@@ sv/psd_pkg.sv @@
// types, constants and helpers of the petscii stream decoder
package psd_pkg;

   localparam int MODE_W = 2;

   typedef logic [MODE_W-1:0] mode_type;

   localparam logic CSR_LF_MODE = 1'b0;
   localparam logic CSR_CR_MODE = 1'b1;

   localparam mode_type LF_MODE_RESET = 2'd2;
   localparam mode_type CR_MODE_RESET = 2'd3;

   typedef enum logic [3:0] {
      ACT_NONE      = 4'd0,
      ACT_PRINT     = 4'd1,
      ACT_COL0      = 4'd2,
      ACT_DOWN      = 4'd3,
      ACT_NEWLINE   = 4'd4,
      ACT_LOWERSET  = 4'd5,
      ACT_UPPERSET  = 4'd6,
      ACT_CRSR_DOWN = 4'd7,
      ACT_HOME      = 4'd8,
      ACT_BACKSPACE = 4'd9,
      ACT_RIGHT     = 4'd10,
      ACT_UP        = 4'd11,
      ACT_CLEAR     = 4'd12,
      ACT_INSERT    = 4'd13,
      ACT_LEFT      = 4'd14
   } action_type;

   // line feed / carriage return mode encodings
   localparam mode_type MODE_NONE     = 2'd0;
   localparam mode_type MODE_COL0     = 2'd1;
   localparam mode_type MODE_DOWN     = 2'd2;
   localparam mode_type MODE_DOWN_COL = 2'd3;

   // petscii control codes
   localparam logic [7:0] CH_LF      = 8'd10;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_LOWER   = 8'd14;
   localparam logic [7:0] CH_DOWN    = 8'd17;
   localparam logic [7:0] CH_RVS_ON  = 8'd18;
   localparam logic [7:0] CH_HOME    = 8'd19;
   localparam logic [7:0] CH_DEL     = 8'd20;
   localparam logic [7:0] CH_RIGHT   = 8'd29;
   localparam logic [7:0] CH_QUOTE   = 8'd34;
   localparam logic [7:0] CH_CR_SH   = 8'd141;
   localparam logic [7:0] CH_UPPER   = 8'd142;
   localparam logic [7:0] CH_UP      = 8'd145;
   localparam logic [7:0] CH_RVS_OFF = 8'd146;
   localparam logic [7:0] CH_CLEAR   = 8'd147;
   localparam logic [7:0] CH_INSERT  = 8'd148;
   localparam logic [7:0] CH_LEFT    = 8'd157;

   localparam logic [3:0] COLOUR_RESET = 4'd1;
   localparam logic [7:0] INSERT_MAX   = 8'd255;

   typedef struct packed {
      logic       quote_on;
      logic [7:0] insert_pending;
      logic       lower_set;
      logic [3:0] colour_now;
      logic       reverse_on;
   } psd_state_type;

   localparam psd_state_type STATE_RESET = '{
      quote_on: 1'b0, insert_pending: 8'd0, lower_set: 1'b1,
      colour_now: COLOUR_RESET, reverse_on: 1'b0
   };

   typedef struct packed {
      action_type action;
      logic [7:0] glyph;
      logic [3:0] fg_colour;
      logic       inverse;
   } psd_result_type;

   function automatic action_type mode_action(input mode_type m);
      action_type a;
      unique case (m)
         MODE_NONE:     a = ACT_NONE;
         MODE_COL0:     a = ACT_COL0;
         MODE_DOWN:     a = ACT_DOWN;
         MODE_DOWN_COL: a = ACT_NEWLINE;
         default:       a = ACT_NONE;
      endcase
      return a;
   endfunction

endpackage

@@ sv/psd_channels.sv @@
// valid/ready channel interfaces for requests and responses
interface psd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] action;
   logic [7:0] glyph;
   logic [3:0] fg_colour;
   logic       inverse;

   modport source (output valid, output action, output glyph, output fg_colour,
                   output inverse, input ready);
   modport sink   (input valid, input action, input glyph, input fg_colour,
                   input inverse, output ready);
endinterface

@@ sv/psd_decode.sv @@
// combinational decode of one petscii byte against the terminal state
module psd_decode (
   input  logic [7:0]              rx_byte,
   input  psd_pkg::psd_state_type  state,
   input  psd_pkg::mode_type       lf_mode,
   input  psd_pkg::mode_type       cr_mode,
   output psd_pkg::psd_state_type  state_next,
   output psd_pkg::psd_result_type result
);
   import psd_pkg::*;

   typedef struct packed {
      logic       hit;
      logic [3:0] value;
   } colour_hit_type;

   function automatic logic [7:0] ctl_glyph(input logic [7:0] c, input logic lower);
      logic [7:0] g;
      case (c)
         8'd27:   g = 8'h5B;
         8'd28:   g = 8'h9A;
         8'd29:   g = 8'h5D;
         8'd30:   g = 8'h98;
         8'd31:   g = 8'h99;
         8'd155:  g = 8'h9B;
         8'd156:  g = 8'h9C;
         8'd157:  g = 8'h9D;
         8'd158:  g = lower ? 8'h9E : 8'hCE;
         8'd159:  g = lower ? 8'h9F : 8'hDF;
         default: begin
            if (c < 8'd32) g = lower ? 8'(c + 8'd96) : 8'(c + 8'd64);
            else           g = lower ? 8'(c - 8'd64) : 8'(c + 8'd64);
         end
      endcase
      return g;
   endfunction

   function automatic logic [7:0] print_glyph(input logic [7:0] c, input logic lower);
      logic [7:0] g;
      if (c >= 8'd65 && c <= 8'd90 && lower) begin
         g = 8'(c + 8'd32);
      end else if (c >= 8'd97 && c <= 8'd122) begin
         g = lower ? 8'(c - 8'd32) : 8'(c + 8'd96);
      end else if (c >= 8'd149 && c <= 8'd191 && c != 8'd169 && c != 8'd186) begin
         g = 8'(c + 8'd64);
      end else if (c >= 8'd133 && c <= 8'd140) begin
         g = 8'd0;
      end else begin
         case (c)
            8'd92:   g = 8'h9A;
            8'd94:   g = 8'h98;
            8'd95:   g = 8'h99;
            8'd96:   g = 8'hC0;
            8'd123:  g = 8'h9B;
            8'd124:  g = 8'h9C;
            8'd125:  g = 8'h9D;
            8'd126:  g = lower ? 8'h9E : 8'hDE;
            8'd127:  g = lower ? 8'h9F : 8'hDF;
            8'd169:  g = lower ? 8'hA9 : 8'hE9;
            8'd186:  g = lower ? 8'hBA : 8'hFA;
            default: g = c;
         endcase
      end
      return g;
   endfunction

   function automatic colour_hit_type colour_lookup(input logic [7:0] c);
      colour_hit_type r;
      r.hit = 1'b1;
      case (c)
         8'd5:    r.value = 4'd1;
         8'd28:   r.value = 4'd2;
         8'd30:   r.value = 4'd5;
         8'd31:   r.value = 4'd6;
         8'd129:  r.value = 4'd8;
         8'd144:  r.value = 4'd0;
         8'd149:  r.value = 4'd9;
         8'd150:  r.value = 4'd10;
         8'd151:  r.value = 4'd11;
         8'd152:  r.value = 4'd12;
         8'd153:  r.value = 4'd13;
         8'd154:  r.value = 4'd14;
         8'd155:  r.value = 4'd15;
         8'd156:  r.value = 4'd4;
         8'd158:  r.value = 4'd7;
         8'd159:  r.value = 4'd3;
         default: begin
            r.hit   = 1'b0;
            r.value = 4'd0;
         end
      endcase
      return r;
   endfunction

   logic [7:0]     code;
   logic           quote_t;
   logic           lo_ctl;
   logic           hi_ctl;
   logic           ins_busy;
   logic [7:0]     ins_dec;
   logic [7:0]     pglyph;
   colour_hit_type colour;

   // fold 192-255 onto the lower code ranges
   always_comb begin
      if (rx_byte <= 8'd191)      code = rx_byte;
      else if (rx_byte <= 8'd223) code = 8'(rx_byte - 8'd96);
      else if (rx_byte <= 8'd254) code = 8'(rx_byte - 8'd64);
      else                        code = 8'd126;
   end

   assign quote_t  = state.quote_on ^ (code == CH_QUOTE);
   assign lo_ctl   = (code < 8'd32) && (code != CH_CR) && !(quote_t && code == CH_DEL);
   assign hi_ctl   = (code >= 8'd128) && (code < 8'd160) && (quote_t || code != CH_INSERT);
   assign ins_busy = (state.insert_pending != 8'd0);
   assign ins_dec  = ins_busy ? 8'(state.insert_pending - 8'd1) : 8'd0;
   assign pglyph   = print_glyph(code, state.lower_set);
   assign colour   = colour_lookup(code);

   always_comb begin
      state_next          = state;
      state_next.quote_on = quote_t;
      result              = '{action: ACT_NONE, glyph: 8'd0,
                              fg_colour: state.colour_now, inverse: 1'b0};

      if ((quote_t || ins_busy) && (lo_ctl || hi_ctl)) begin
         // control code shown as a reversed glyph
         state_next.insert_pending = ins_dec;
         result.action             = ACT_PRINT;
         result.glyph              = ctl_glyph(code, state.lower_set);
         result.inverse            = 1'b1;
      end else if (colour.hit) begin
         state_next.colour_now = colour.value;
         result.fg_colour      = colour.value;
      end else begin
         unique case (code)
            CH_LF: result.action = mode_action(lf_mode);
            CH_CR, CH_CR_SH: begin
               result.action             = mode_action(cr_mode);
               state_next.insert_pending = 8'd0;
               state_next.quote_on       = 1'b0;
               state_next.reverse_on     = 1'b0;
            end
            CH_LOWER: begin
               state_next.lower_set = 1'b1;
               result.action        = ACT_LOWERSET;
            end
            CH_UPPER: begin
               state_next.lower_set = 1'b0;
               result.action        = ACT_UPPERSET;
            end
            CH_DOWN:    result.action = ACT_CRSR_DOWN;
            CH_RVS_ON:  state_next.reverse_on = 1'b1;
            CH_HOME:    result.action = ACT_HOME;
            CH_DEL:     result.action = ACT_BACKSPACE;
            CH_RIGHT:   result.action = ACT_RIGHT;
            CH_UP:      result.action = ACT_UP;
            CH_RVS_OFF: state_next.reverse_on = 1'b0;
            CH_CLEAR:   result.action = ACT_CLEAR;
            CH_INSERT: begin
               result.action = ACT_INSERT;
               if (state.insert_pending != INSERT_MAX) begin
                  state_next.insert_pending = 8'(state.insert_pending + 8'd1);
               end
            end
            CH_LEFT:    result.action = ACT_LEFT;
            default: begin
               state_next.insert_pending = ins_dec;
               if (pglyph != 8'd0) begin
                  result.action  = ACT_PRINT;
                  result.glyph   = pglyph;
                  result.inverse = state.reverse_on;
               end
            end
         endcase
      end
   end

endmodule

@@ sv/petscii_stream_decoder.sv @@
// petscii stream decoder top level: input stage, decode, terminal state and response stage
// a byte taken into the input register is decoded and then moved into the response register
// throughput: one byte per cycle while responses are taken; the terminal state updates as a byte
//   moves into the response register, so each byte sees the state left by the byte before it
// the input and response registers stall independently, so a byte is taken while a response waits
// reset (synchronous, active high) empties both stages, restores the terminal state and the modes
`include "petscii_stream_decoder_defines.svh"

module petscii_stream_decoder (
   input  logic                  clock,
   input  logic                  reset,
   psd_req_if.sink               req_chan,
   psd_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [psd_pkg::MODE_W-1:0] csr_wdata
);
   import psd_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   psd_result_type rsp_data_ff;
   psd_result_type dec_result;
   psd_state_type  state_ff, state_in;
   mode_type       lf_mode_ff, cr_mode_ff;
   logic           advance;
   logic           req_take;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   psd_decode u_decode (
      .rx_byte    (in_byte_ff),
      .state      (state_ff),
      .lf_mode    (lf_mode_ff),
      .cr_mode    (cr_mode_ff),
      .state_next (state_in),
      .result     (dec_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
         lf_mode_ff   <= LF_MODE_RESET;
         cr_mode_ff   <= CR_MODE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_LF_MODE: lf_mode_ff <= csr_wdata;
               CSR_CR_MODE: cr_mode_ff <= csr_wdata;
               default:     ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) in_byte_ff  <= req_chan.rx_byte;
      if (advance)  rsp_data_ff <= dec_result;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.action    = rsp_data_ff.action;
   assign rsp_chan.glyph     = rsp_data_ff.glyph;
   assign rsp_chan.fg_colour = rsp_data_ff.fg_colour;
   assign rsp_chan.inverse   = rsp_data_ff.inverse;

   `PSD_ASSERT_SAME(a_inverse_only_print, clock, reset,
      rsp_valid_ff && rsp_data_ff.inverse, rsp_data_ff.action == ACT_PRINT)
   `PSD_ASSERT_SAME(a_print_has_glyph, clock, reset,
      rsp_valid_ff && rsp_data_ff.action == ACT_PRINT, rsp_data_ff.glyph != 8'd0)
   `PSD_ASSERT_SAME(a_glyph_only_print, clock, reset,
      rsp_valid_ff && rsp_data_ff.action != ACT_PRINT, rsp_data_ff.glyph == 8'd0)
   `PSD_ASSERT_NEXT(a_state_holds_idle, clock, reset, !advance, $stable(state_ff))
   `PSD_ASSERT_NEXT(a_insert_step, clock, reset, 1'b1,
      state_ff.insert_pending == $past(state_ff.insert_pending) ||
      state_ff.insert_pending == 8'($past(state_ff.insert_pending) + 8'd1) ||
      state_ff.insert_pending == 8'($past(state_ff.insert_pending) - 8'd1) ||
      state_ff.insert_pending == 8'd0)

endmodule

@@ tb/tb_petscii_stream_decoder.sv @@
// self-checking testbench for the petscii stream decoder: directed table, then random byte streams
module tb_petscii_stream_decoder;
   import psd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0]     rx;
      bit             typed;
      psd_result_type lit;
   } row_type;

   localparam psd_result_type NO_LIT = '{ACT_NONE, 8'd0, 4'd0, 1'b0};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_index = CSR_LF_MODE;
   mode_type csr_wdata = MODE_NONE;

   psd_req_if req_if ();
   psd_rsp_if rsp_if ();

   petscii_stream_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // terminal state and line modes as the predictor sees them
   psd_state_type term;
   mode_type lf_sel;
   mode_type cr_sel;

   psd_result_type display_actions_due[$];
   int bytes_sent = 0;
   int actions_seen = 0;
   int mismatches = 0;
   bit calm = 1'b0;

   function automatic psd_result_type decode_petscii(input logic [7:0] rx);
      logic [7:0] c;
      logic [7:0] g;
      mode_type m;
      psd_result_type r;
      c = rx;
      if (rx >= 8'd192) begin
         if (rx <= 8'd223) c = rx - 8'd96;
         else if (rx <= 8'd254) c = rx - 8'd64;
         else c = 8'd126;
      end
      if (c == CH_QUOTE) term.quote_on = !term.quote_on;
      r = '{ACT_NONE, 8'd0, 4'd0, 1'b0};
      g = 8'd0;

      // quote or insert mode: control codes are drawn as reversed glyphs
      if (term.quote_on || term.insert_pending != 8'd0) begin
         if (c < 8'd32 && c != CH_CR && !(term.quote_on && c == CH_DEL)) begin
            case (c)
               8'd27: g = 8'h5B;
               8'd28: g = 8'h9A;
               8'd29: g = 8'h5D;
               8'd30: g = 8'h98;
               8'd31: g = 8'h99;
               default: g = term.lower_set ? c + 8'd96 : c + 8'd64;
            endcase
         end else if (c >= 8'd128 && c < 8'd160 && (term.quote_on || c != CH_INSERT)) begin
            case (c)
               8'd155: g = 8'h9B;
               8'd156: g = 8'h9C;
               8'd157: g = 8'h9D;
               8'd158: g = term.lower_set ? 8'h9E : 8'hCE;
               8'd159: g = term.lower_set ? 8'h9F : 8'hDF;
               default: g = term.lower_set ? c - 8'd64 : c + 8'd64;
            endcase
         end
      end
      if (g != 8'd0) begin
         if (term.insert_pending != 8'd0) term.insert_pending--;
         r = '{ACT_PRINT, g, term.colour_now, 1'b1};
         return r;
      end

      case (c)
         8'd5:   term.colour_now = 4'd1;
         8'd28:  term.colour_now = 4'd2;
         8'd30:  term.colour_now = 4'd5;
         8'd31:  term.colour_now = 4'd6;
         8'd129: term.colour_now = 4'd8;
         8'd144: term.colour_now = 4'd0;
         8'd149: term.colour_now = 4'd9;
         8'd150: term.colour_now = 4'd10;
         8'd151: term.colour_now = 4'd11;
         8'd152: term.colour_now = 4'd12;
         8'd153: term.colour_now = 4'd13;
         8'd154: term.colour_now = 4'd14;
         8'd155: term.colour_now = 4'd15;
         8'd156: term.colour_now = 4'd4;
         8'd158: term.colour_now = 4'd7;
         8'd159: term.colour_now = 4'd3;
         CH_LF, CH_CR, CH_CR_SH: begin
            m = (c == CH_LF) ? lf_sel : cr_sel;
            case (m)
               MODE_COL0:     r.action = ACT_COL0;
               MODE_DOWN:     r.action = ACT_DOWN;
               MODE_DOWN_COL: r.action = ACT_NEWLINE;
               default:       r.action = ACT_NONE;
            endcase
            if (c != CH_LF) begin
               term.insert_pending = 8'd0;
               term.quote_on = 1'b0;
               term.reverse_on = 1'b0;
            end
         end
         CH_LOWER: begin
            term.lower_set = 1'b1;
            r.action = ACT_LOWERSET;
         end
         CH_UPPER: begin
            term.lower_set = 1'b0;
            r.action = ACT_UPPERSET;
         end
         CH_DOWN:    r.action = ACT_CRSR_DOWN;
         CH_RVS_ON:  term.reverse_on = 1'b1;
         CH_HOME:    r.action = ACT_HOME;
         CH_DEL:     r.action = ACT_BACKSPACE;
         CH_RIGHT:   r.action = ACT_RIGHT;
         CH_UP:      r.action = ACT_UP;
         CH_RVS_OFF: term.reverse_on = 1'b0;
         CH_CLEAR:   r.action = ACT_CLEAR;
         CH_INSERT: begin
            r.action = ACT_INSERT;
            if (term.insert_pending != INSERT_MAX) term.insert_pending++;
         end
         CH_LEFT:    r.action = ACT_LEFT;
         default: begin
            if (c >= 8'd65 && c <= 8'd90 && term.lower_set) g = c + 8'd32;
            else if (c >= 8'd97 && c <= 8'd122)
               g = term.lower_set ? c - 8'd32 : c + 8'd96;
            else if (c >= 8'd149 && c <= 8'd191 && c != 8'd169 && c != 8'd186)
               g = c + 8'd64;
            else if (c >= 8'd133 && c <= 8'd140) g = 8'd0;
            else begin
               case (c)
                  8'd92:  g = 8'h9A;
                  8'd94:  g = 8'h98;
                  8'd95:  g = 8'h99;
                  8'd96:  g = 8'hC0;
                  8'd123: g = 8'h9B;
                  8'd124: g = 8'h9C;
                  8'd125: g = 8'h9D;
                  8'd126: g = term.lower_set ? 8'h9E : 8'hDE;
                  8'd127: g = term.lower_set ? 8'h9F : 8'hDF;
                  8'd169: g = term.lower_set ? 8'hA9 : 8'hE9;
                  8'd186: g = term.lower_set ? 8'hBA : 8'hFA;
                  default: g = c;
               endcase
            end
            if (g != 8'd0) begin
               r.action = ACT_PRINT;
               r.glyph = g;
               r.inverse = term.reverse_on;
            end
            if (term.insert_pending != 8'd0) term.insert_pending--;
         end
      endcase
      r.fg_colour = term.colour_now;
      return r;
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input psd_result_type lit = NO_LIT);
      int gap;
      psd_result_type predicted;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = decode_petscii(b);
      display_actions_due.push_back(typed ? lit : predicted);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (display_actions_due.size() != 0) @(posedge clock);
   endtask

   // both registers go in back to back while the block is idle
   task automatic set_modes(input mode_type lf, input mode_type cr);
      csr_we <= 1'b1;
      csr_index <= CSR_LF_MODE;
      csr_wdata <= lf;
      @(posedge clock);
      csr_index <= CSR_CR_MODE;
      csr_wdata <= cr;
      @(posedge clock);
      csr_we <= 1'b0;
      lf_sel = lf;
      cr_sel = cr;
   endtask

   initial begin : stimulus
      row_type directed[$];
      logic [7:0] ctrl_pool[$];
      mode_type lf_plan[$];
      mode_type cr_plan[$];
      int quota;
      int n;
      int kind;
      int phase_i;

      req_if.valid = 1'b0;
      req_if.rx_byte = 8'd0;
      term = '{quote_on: 1'b0, insert_pending: 8'd0, lower_set: 1'b1,
               colour_now: 4'd1, reverse_on: 1'b0};
      lf_sel = MODE_DOWN;
      cr_sel = MODE_DOWN_COL;

      directed = '{
         '{8'd65,      1'b1, '{ACT_PRINT,   8'd97, 4'd1, 1'b0}},
         '{8'd0,       1'b1, '{ACT_NONE,    8'd0,  4'd1, 1'b0}},
         '{8'd255,     1'b0, NO_LIT},
         '{CH_LF,      1'b1, '{ACT_DOWN,    8'd0,  4'd1, 1'b0}},
         '{CH_CR,      1'b1, '{ACT_NEWLINE, 8'd0,  4'd1, 1'b0}},
         '{CH_RVS_ON,  1'b0, NO_LIT},
         '{8'd97,      1'b0, NO_LIT},
         '{CH_RVS_OFF, 1'b0, NO_LIT},
         '{8'd28,      1'b1, '{ACT_NONE,    8'd0,  4'd2, 1'b0}},
         '{CH_UPPER,   1'b0, NO_LIT},
         '{8'd126,     1'b0, NO_LIT},
         '{CH_LOWER,   1'b0, NO_LIT},
         '{CH_DOWN,    1'b0, NO_LIT},
         '{CH_HOME,    1'b0, NO_LIT},
         '{CH_DEL,     1'b0, NO_LIT},
         '{CH_RIGHT,   1'b0, NO_LIT},
         '{CH_UP,      1'b0, NO_LIT},
         '{CH_CLEAR,   1'b0, NO_LIT},
         '{CH_LEFT,    1'b0, NO_LIT},
         '{CH_INSERT,  1'b0, NO_LIT},
         '{8'd5,       1'b0, NO_LIT},
         '{CH_QUOTE,   1'b0, NO_LIT},
         '{CH_DEL,     1'b0, NO_LIT},
         '{CH_INSERT,  1'b0, NO_LIT},
         '{CH_CR_SH,   1'b0, NO_LIT},
         '{8'd133,     1'b0, NO_LIT},
         '{8'd224,     1'b0, NO_LIT},
         '{8'd191,     1'b0, NO_LIT}
      };
      ctrl_pool = '{CH_LF, CH_CR, CH_LOWER, CH_DOWN, CH_RVS_ON, CH_HOME, CH_DEL,
                    CH_RIGHT, CH_QUOTE, CH_CR_SH, CH_UPPER, CH_UP, CH_RVS_OFF,
                    CH_CLEAR, CH_INSERT, CH_LEFT, 8'd5, 8'd28, 8'd30, 8'd31,
                    8'd129, 8'd144, 8'd149, 8'd155, 8'd158, 8'd159, 8'd27,
                    8'd0, 8'd133};
      lf_plan = '{MODE_NONE, MODE_DOWN_COL, MODE_COL0, MODE_DOWN, MODE_DOWN_COL, MODE_NONE};
      cr_plan = '{MODE_NONE, MODE_DOWN_COL, MODE_DOWN, MODE_COL0, MODE_NONE, MODE_DOWN_COL};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_byte(directed[i].rx, directed[i].typed, directed[i].lit);

      for (phase_i = 0; phase_i < lf_plan.size(); phase_i++) begin
         wait_drained();
         set_modes(lf_plan[phase_i], cr_plan[phase_i]);
         // drive the insert count into saturation twice in the run
         if (phase_i == 0 || phase_i == lf_plan.size() - 1) begin
            calm = 1'b1;
            // leave quote mode so the inserts are counted
            send_byte(CH_CR);
            repeat ($urandom_range(256, 262)) send_byte(CH_INSERT);
         end
         quota = bytes_sent + 250;
         while (bytes_sent < quota) begin
            calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            case (kind)
               0, 1, 2, 3: send_byte(8'($urandom_range(0, 255)));
               4, 5: begin
                  send_byte(CH_QUOTE);
                  repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(0, 255)));
                  send_byte(CH_QUOTE);
               end
               6: begin
                  n = $urandom_range(1, 6);
                  repeat (n) send_byte(CH_INSERT);
                  repeat (n + $urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
               end
               7: repeat ($urandom_range(1, 10))
                     send_byte(8'($urandom_range(0, 1) ? $urandom_range(32, 127)
                                                       : $urandom_range(160, 254)));
               default: send_byte(ctrl_pool[$urandom_range(0, ctrl_pool.size() - 1)]);
            endcase
         end
      end

      calm = 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      $display("decoded %0d bytes over %0d line mode settings, %0d display actions checked",
               bytes_sent, lf_plan.size() + 1, actions_seen);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : response_sink
      int stall;
      psd_result_type want;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 18);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         actions_seen++;
         if (display_actions_due.size() == 0) begin
            $error("unexpected transaction: action %0d glyph %0d", rsp_if.action, rsp_if.glyph);
            mismatches++;
         end else begin
            want = display_actions_due.pop_front();
            if (rsp_if.action != want.action) begin
               $error("action: expected %0d, got %0d", want.action, rsp_if.action);
               mismatches++;
            end
            if (rsp_if.glyph != want.glyph) begin
               $error("glyph: expected %0d, got %0d", want.glyph, rsp_if.glyph);
               mismatches++;
            end
            if (rsp_if.fg_colour != want.fg_colour) begin
               $error("fg_colour: expected %0d, got %0d", want.fg_colour, rsp_if.fg_colour);
               mismatches++;
            end
            if (rsp_if.inverse != want.inverse) begin
               $error("inverse: expected %0d, got %0d", want.inverse, rsp_if.inverse);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/psd_pkg.sv
sv/psd_channels.sv
sv/psd_decode.sv
sv/petscii_stream_decoder.sv
tb/tb_petscii_stream_decoder.sv
